@@ design/cubic_bezier_evaluator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator assertion macros
// Concurrent assertion wrappers that report by $error and drop out of
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EVALUATOR_TOP_ASSERT_SVH
`define CUBIC_BEZIER_EVALUATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CBE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define CBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CBE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator package
// Fixed widths, register indexes and arithmetic constants of the evaluator.
// ----------------------------------------------------------------------------
package cbe_pkg;

   // Field and register widths fixed by the interface.
   localparam int PROGRESS_W  = 17;
   localparam int CTRL_W      = 48;
   localparam int DUR_W       = 16;
   localparam int RES_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int NUM_OUT     = 3;
   localparam int NUM_CTRL    = 4;

   // Progress value of one in Q1.16.
   localparam logic [PROGRESS_W-1:0] ONE_Q16 = 17'h10000;

   // Weight widths: squares in Q1.32 and cubes in Q1.48, one integer bit each.
   localparam int SQ_W = 33;
   localparam int CU_W = 49;
   // Cube weights are split into a high and a low part for the multipliers.
   localparam int WL_W = 24;
   localparam int WH_W = CU_W - WL_W;

   // Position rounding: half an output step in units of 2^-56, and the shifts.
   localparam logic [63:0] POS_ROUND    = 64'd1 << 39;
   localparam int          POS_LO_SHIFT = 24;
   localparam int          POS_HI_SHIFT = 16;

   // Derivative scaling: the divisor is duration * 2^16, half of it rounds.
   localparam int DIV_SCALE_SHIFT = 16;
   localparam int DIV_HALF_SHIFT  = 15;
   // Quotient bits resolved in one divider stage.
   localparam int DIV_BPS = 4;

   // Output saturation limits.
   localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;
   localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

   // Duration after reset: 1.0 in Q8.8.
   localparam logic [DUR_W-1:0] DUR_RESET = 16'd256;

   // Request type that asks for the time derivative.
   localparam logic REQ_DERIVATIVE = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CTRL_POINT_0   = 3'd0,
      CSR_CTRL_POINT_1   = 3'd1,
      CSR_CTRL_POINT_2   = 3'd2,
      CSR_CTRL_POINT_3   = 3'd3,
      CSR_CURVE_DURATION = 3'd4
   } csr_index_type;

   typedef logic [NUM_OUT-1:0][RES_W-1:0] res_vec_type;

endpackage

@@ design/cubic_bezier_evaluator_top.sv @@
// An accepted item passes the weight stages, the lane stages, the restoring divider
// stages (four quotient bits per stage), a result register and the output register.
// Throughput: one item per cycle while results are taken; the pipeline stalls while the
// skid entry is full. Reset clears all valid bits, which empties the pipeline and the
// output buffer, and loads the register defaults (control points zero, duration 1.0).
// ----------------------------------------------------------------------------
// Cubic Bezier curve evaluator
// Pipelined evaluation of a cubic Bezier position or its time derivative for
// up to three components, with a pipelined restoring divider for the duration.
// ----------------------------------------------------------------------------
`include "cubic_bezier_evaluator_top_assert.svh"

module cubic_bezier_evaluator_top
   import cbe_pkg::*;
#(
   parameter int DIM         = 3,
   parameter int COORD_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // Configuration write channel.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CTRL_W-1:0]       csr_wdata,
   // Request channel.
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic [PROGRESS_W-1:0]   req_progress,
   // Result channel.
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [RES_W-1:0] rsp_out_x,
   output logic signed [RES_W-1:0] rsp_out_y,
   output logic signed [RES_W-1:0] rsp_out_z
);

   // Derived widths.
   localparam int CW     = COORD_WIDTH;
   localparam int NL     = (DIM < NUM_OUT) ? DIM : NUM_OUT;
   localparam int PH_W   = CW + WH_W + 1;
   localparam int PL_W   = CW + WL_W + 1;
   localparam int HI_W   = PH_W + 2;
   localparam int LO_W   = (PL_W + 2 > 41) ? PL_W + 2 : 41;
   localparam int LQ_W   = LO_W - POS_LO_SHIFT;
   localparam int POS_W  = HI_W + 1 - POS_HI_SHIFT;
   localparam int DP_W   = CW + 1 + SQ_W + 1;
   localparam int V_W    = DP_W + 4;
   localparam int NW     = CW + 18;
   localparam int DS     = (NW + DIV_BPS - 1) / DIV_BPS;
   localparam int NP     = DS * DIV_BPS;
   localparam int QX_W   = (NP > RES_W + 1) ? NP : RES_W + 1;
   localparam int NST    = 8 + DS;

   // Configuration registers.
   logic [CTRL_W-1:0] ctrl_point_ff [NUM_CTRL];
   logic [DUR_W-1:0]  curve_duration_ff;
   logic [DUR_W-1:0]  dur_eff;

   // Pipeline control.
   logic             adv;
   logic [NST-1:0]   vld_ff;
   logic [NST-1:0]   drv_ff;
   logic             z_valid_ff;
   res_vec_type      z_res_in;
   res_vec_type      z_res_ff;

   // Shared weight stages.
   logic [PROGRESS_W-1:0] t_in, s_in;
   logic [PROGRESS_W-1:0] a_t_ff, a_s_ff;
   logic [PROGRESS_W-1:0] b_t_ff, b_s_ff;
   logic [SQ_W-1:0]       b_ss_ff, b_st_ff, b_tt_ff;
   logic [SQ_W-1:0]       c_ss_ff, c_st_ff, c_tt_ff;
   logic [CU_W-1:0]       c_s3_ff, c_s2t_ff, c_st2_ff, c_t3_ff;
   logic [CU_W-1:0]       d_w_ff  [NUM_CTRL];
   logic [SQ_W-1:0]       d_dw_ff [NUM_CTRL-1];

   // Output buffer with one skid entry.
   logic        rsp_valid_ff, skid_valid_ff;
   res_vec_type out_ff, skid_ff;
   logic        push, take;

   // ------------------------------------------------------------------
   // Configuration port.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CTRL; i++) begin
            ctrl_point_ff[i] <= '0;
         end
         curve_duration_ff <= DUR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CTRL_POINT_0:   ctrl_point_ff[0] <= csr_wdata;
            CSR_CTRL_POINT_1:   ctrl_point_ff[1] <= csr_wdata;
            CSR_CTRL_POINT_2:   ctrl_point_ff[2] <= csr_wdata;
            CSR_CTRL_POINT_3:   ctrl_point_ff[3] <= csr_wdata;
            CSR_CURVE_DURATION: curve_duration_ff <= csr_wdata[DUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A zero duration behaves as the smallest step.
   assign dur_eff = (curve_duration_ff == '0) ? DUR_W'(1) : curve_duration_ff;

   // ------------------------------------------------------------------
   // Pipeline control: the whole pipeline moves unless the skid entry is full.
   // ------------------------------------------------------------------
   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         z_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[NST-2:0], req_valid};
         z_valid_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         drv_ff <= {drv_ff[NST-2:0], req_type == REQ_DERIVATIVE};
      end
   end

   // ------------------------------------------------------------------
   // Shared weights: clamp t, then squares, cubes and scaled weights.
   // ------------------------------------------------------------------
   assign t_in = (req_progress > ONE_Q16) ? ONE_Q16 : req_progress;
   assign s_in = ONE_Q16 - t_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_t_ff   <= t_in;
         a_s_ff   <= s_in;

         b_t_ff   <= a_t_ff;
         b_s_ff   <= a_s_ff;
         b_ss_ff  <= SQ_W'(a_s_ff) * SQ_W'(a_s_ff);
         b_st_ff  <= SQ_W'(a_s_ff) * SQ_W'(a_t_ff);
         b_tt_ff  <= SQ_W'(a_t_ff) * SQ_W'(a_t_ff);

         c_ss_ff  <= b_ss_ff;
         c_st_ff  <= b_st_ff;
         c_tt_ff  <= b_tt_ff;
         c_s3_ff  <= CU_W'(b_ss_ff) * CU_W'(b_s_ff);
         c_s2t_ff <= CU_W'(b_ss_ff) * CU_W'(b_t_ff);
         c_st2_ff <= CU_W'(b_tt_ff) * CU_W'(b_s_ff);
         c_t3_ff  <= CU_W'(b_tt_ff) * CU_W'(b_t_ff);

         d_w_ff[0]  <= c_s3_ff;
         d_w_ff[1]  <= c_s2t_ff + (c_s2t_ff << 1);
         d_w_ff[2]  <= c_st2_ff + (c_st2_ff << 1);
         d_w_ff[3]  <= c_t3_ff;
         d_dw_ff[0] <= c_ss_ff;
         d_dw_ff[1] <= c_st_ff << 1;
         d_dw_ff[2] <= c_tt_ff;
      end
   end

   // ------------------------------------------------------------------
   // Component lanes.
   // ------------------------------------------------------------------
   for (genvar j = 0; j < NUM_OUT; j++) begin : g_lane
      if (j < NL) begin : g_active
         logic signed [CW-1:0]    p  [NUM_CTRL];
         logic signed [CW:0]      dd [NUM_CTRL-1];
         logic signed [PH_W-1:0]  e_ph_ff [NUM_CTRL];
         logic signed [PL_W-1:0]  e_pl_ff [NUM_CTRL];
         logic signed [DP_W-1:0]  e_dp_ff [NUM_CTRL-1];
         logic signed [HI_W-1:0]  f_hi_ff;
         logic signed [LO_W-1:0]  f_lo_ff;
         logic signed [V_W-1:0]   f_v_ff;
         logic [LO_W-1:0]         g_lo_r;
         logic signed [LQ_W-1:0]  g_lq;
         logic signed [HI_W:0]    g_pos_sum;
         logic signed [POS_W-1:0] g_pos_ff;
         logic [V_W-1:0]          g_v3_ff;
         logic [V_W-1:0]          h_half, h_sum;
         logic [NW-1:0]           h_n_ff;
         logic                    h_neg_ff;
         logic signed [POS_W-1:0] h_pos_ff;
         logic [DUR_W-1:0]        dv_rem_ff [DS];
         logic [NP-1:0]           dv_num_ff [DS];
         logic [NP-1:0]           dv_quo_ff [DS];
         logic                    dv_neg_ff [DS];
         logic signed [POS_W-1:0] dv_pos_ff [DS];
         logic [QX_W-1:0]         qx;
         logic [RES_W-1:0]        lane_res;

         // Coordinates of this component and their forward differences.
         always_comb begin
            for (int i = 0; i < NUM_CTRL; i++) begin
               p[i] = $signed(ctrl_point_ff[i][j*CW +: CW]);
            end
            for (int i = 0; i < NUM_CTRL - 1; i++) begin
               dd[i] = (CW+1)'(p[i+1]) - (CW+1)'(p[i]);
            end
         end

         // Products with the position and derivative weights.
         always_ff @(posedge clock) begin
            if (adv) begin
               for (int i = 0; i < NUM_CTRL; i++) begin
                  e_ph_ff[i] <= $signed(PH_W'(p[i])) *
                                $signed(PH_W'(d_w_ff[i][CU_W-1:WL_W]));
                  e_pl_ff[i] <= $signed(PL_W'(p[i])) *
                                $signed(PL_W'(d_w_ff[i][WL_W-1:0]));
               end
               for (int i = 0; i < NUM_CTRL - 1; i++) begin
                  e_dp_ff[i] <= $signed(DP_W'(dd[i])) * $signed(DP_W'(d_dw_ff[i]));
               end
            end
         end

         // Sums of the partial products.
         always_ff @(posedge clock) begin
            if (adv) begin
               f_hi_ff <= HI_W'(e_ph_ff[0]) + HI_W'(e_ph_ff[1]) +
                          HI_W'(e_ph_ff[2]) + HI_W'(e_ph_ff[3]);
               f_lo_ff <= LO_W'(e_pl_ff[0]) + LO_W'(e_pl_ff[1]) +
                          LO_W'(e_pl_ff[2]) + LO_W'(e_pl_ff[3]);
               f_v_ff  <= V_W'(e_dp_ff[0]) + V_W'(e_dp_ff[1]) + V_W'(e_dp_ff[2]);
            end
         end

         // Position rounding half up to Q16.16; derivative times three.
         assign g_lo_r    = f_lo_ff + LO_W'(POS_ROUND);
         assign g_lq      = g_lo_r[LO_W-1:POS_LO_SHIFT];
         assign g_pos_sum = (HI_W+1)'(f_hi_ff) + (HI_W+1)'(g_lq);

         always_ff @(posedge clock) begin
            if (adv) begin
               g_pos_ff <= g_pos_sum[HI_W:POS_HI_SHIFT];
               g_v3_ff  <= f_v_ff + (f_v_ff << 1);
            end
         end

         // Magnitude plus half the divisor, pre-divided by 2^16.
         assign h_half = V_W'(dur_eff) << DIV_HALF_SHIFT;
         assign h_sum  = g_v3_ff[V_W-1] ? (h_half - g_v3_ff) : (h_half + g_v3_ff);

         always_ff @(posedge clock) begin
            if (adv) begin
               h_n_ff   <= h_sum[DIV_SCALE_SHIFT +: NW];
               h_neg_ff <= g_v3_ff[V_W-1];
               h_pos_ff <= g_pos_ff;
            end
         end

         // Restoring divider by the duration, a few quotient bits per stage.
         for (genvar k = 0; k < DS; k++) begin : g_div
            logic [DUR_W-1:0]        rem_src, rem_w;
            logic [NP-1:0]           num_src, num_w, quo_src, quo_w;
            logic                    neg_src;
            logic signed [POS_W-1:0] pos_src;
            logic [DUR_W:0]          trial;

            if (k == 0) begin : g_first
               assign rem_src = '0;
               assign num_src = NP'(h_n_ff);
               assign quo_src = '0;
               assign neg_src = h_neg_ff;
               assign pos_src = h_pos_ff;
            end else begin : g_next
               assign rem_src = dv_rem_ff[k-1];
               assign num_src = dv_num_ff[k-1];
               assign quo_src = dv_quo_ff[k-1];
               assign neg_src = dv_neg_ff[k-1];
               assign pos_src = dv_pos_ff[k-1];
            end

            always_comb begin
               rem_w = rem_src;
               num_w = num_src;
               quo_w = quo_src;
               trial = '0;
               for (int b = 0; b < DIV_BPS; b++) begin
                  trial = {rem_w, num_w[NP-1]};
                  num_w = num_w << 1;
                  if (trial >= {1'b0, dur_eff}) begin
                     rem_w = DUR_W'(trial - {1'b0, dur_eff});
                     quo_w = {quo_w[NP-2:0], 1'b1};
                  end else begin
                     rem_w = trial[DUR_W-1:0];
                     quo_w = {quo_w[NP-2:0], 1'b0};
                  end
               end
            end

            always_ff @(posedge clock) begin
               if (adv) begin
                  dv_rem_ff[k] <= rem_w;
                  dv_num_ff[k] <= num_w;
                  dv_quo_ff[k] <= quo_w;
                  dv_neg_ff[k] <= neg_src;
                  dv_pos_ff[k] <= pos_src;
               end
            end
         end

         // Sign, saturation and choice between position and derivative.
         assign qx = QX_W'(dv_quo_ff[DS-1]);

         always_comb begin
            if (!drv_ff[NST-1]) begin
               lane_res = RES_W'(dv_pos_ff[DS-1]);
            end else if (dv_neg_ff[DS-1]) begin
               lane_res = (qx > QX_W'(RES_MIN)) ? RES_MIN : (RES_W'(0) - qx[RES_W-1:0]);
            end else begin
               lane_res = (qx > QX_W'(RES_MAX)) ? RES_MAX : qx[RES_W-1:0];
            end
         end

         assign z_res_in[j] = lane_res;
      end else begin : g_unused
         // Components beyond the configured dimension read as zero.
         assign z_res_in[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z_res_ff <= z_res_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register and skid entry.
   // ------------------------------------------------------------------
   assign push = adv && z_valid_ff;
   assign take = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (rsp_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (rsp_valid_ff && !take) begin
            skid_ff <= z_res_ff;
         end else begin
            out_ff <= z_res_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = $signed(out_ff[0]);
   assign rsp_out_y = $signed(out_ff[1]);
   assign rsp_out_z = $signed(out_ff[2]);

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `CBE_ASSERT_IMP(a_skid_has_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid item without an output item")
   `CBE_ASSERT_NEXT(a_blocked_to_skid, clock, reset, push && rsp_valid_ff && !rsp_ready, skid_valid_ff, "blocked item not held in skid")
   `CBE_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(vld_ff) && $stable(z_valid_ff), "pipeline moved while stalled")
   `CBE_ASSERT_NEXT(a_drain_empties, clock, reset, take && !skid_valid_ff && !push, !rsp_valid_ff, "output item repeated after drain")

endmodule
